@@ sv/m7sap_pkg.sv @@
// Shared constants, register codes and types of the mode 7 scanline parameter unit.
package m7sap_pkg;

	localparam int HALF_WIDTH = 120;
	localparam int LINE_COUNT = 160;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CAM_HEIGHT     = 3'd0,
		REG_YAW_SINE       = 3'd1,
		REG_YAW_COSINE     = 3'd2,
		REG_FOCAL_DISTANCE = 3'd3,
		REG_CAM_X          = 3'd4,
		REG_CAM_Z          = 3'd5,
		REG_HORIZON_LINE   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [27:0] cam_height;
		logic signed [9:0]  yaw_sine;
		logic signed [9:0]  yaw_cosine;
		logic [19:0]        focal_distance;
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_z;
		logic [7:0]         horizon_line;
	} cfg_t;

	function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
		asr32 = 32'($signed(x) >>> n);
	endfunction

endpackage

@@ sv/m7sap_line_if.sv @@
// Request channel that carries one scanline number and its reciprocal-depth word.
interface m7sap_line_if;
	logic        valid;
	logic        ready;
	logic [7:0]  line_number;
	logic [15:0] recip_depth;

	modport source (output valid, output line_number, output recip_depth, input ready);
	modport sink (input valid, input line_number, input recip_depth, output ready);
endinterface

@@ sv/m7sap_param_if.sv @@
// Result channel that carries the affine parameters and fog word of one scanline.
interface m7sap_param_if;
	logic               valid;
	logic               ready;
	logic [7:0]         out_line;
	logic signed [15:0] step_a;
	logic signed [15:0] step_c;
	logic signed [31:0] start_x;
	logic signed [31:0] start_y;
	logic [12:0]        fog_blend;

	modport source (output valid, output out_line, output step_a, output step_c,
		output start_x, output start_y, output fog_blend, input ready);
	modport sink (input valid, input out_line, input step_a, input step_c,
		input start_x, input start_y, input fog_blend, output ready);
endinterface

@@ sv/mode7_scanline_affine_params.sv @@
// Top level of the mode 7 scanline affine parameter unit.
// A request on line_in carries a scanline number and its reciprocal-depth word.
// Lines at or above the horizon, or past the last screen line, are accepted
// and dropped without a result. Every other line yields one result on
// params_out: the affine steps pa and pc, the start coordinates and the fog
// blend word, in request order.
// Registers are written through wr_en, wr_index and wr_data; an unknown index
// is ignored. The user must write only while the unit is idle (unchecked).
// The datapath is a four-stage pipeline: scale product, rotation products,
// offset and focal products, then the final sums. One request can be
// accepted in every cycle unless the receiver stalls. The last stage is
// the output register; when the receiver stalls, each stage holds while
// its successor is full and bubbles are squeezed out, so nothing is lost
// or repeated.
// Reset clears all stage valid bits and loads the register defaults: every
// register zero except the yaw cosine, which is 256.
module mode7_scanline_affine_params (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [m7sap_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [m7sap_pkg::CFG_DATA_W-1:0]  wr_data,
	m7sap_line_if.sink                       line_in,
	m7sap_param_if.source                    params_out
);
	import m7sap_pkg::*;

	cfg_t cfg;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic keep;

	logic [7:0]  line_s1, line_s2, line_s3, line_s4;
	logic [31:0] prod_s1;
	logic [31:0] cprod_s2, sprod_s2;
	logic [4:0]  w_s2, w_s3;
	logic [31:0] pa_s3, pc_s3, offx_s3, offy_s3, rotx_s3, roty_s3;
	logic [15:0] pa_s4, pc_s4;
	logic [31:0] sx_s4, sy_s4;
	logic [12:0] fog_s4;

	logic [31:0] ch_ext, cos_ext, sin_ext, d_ext;
	logic [31:0] lam, lam6, w32;
	logic [4:0]  w_c;
	logic [31:0] lcf, lsf, pa_c, pc_c;

	m7sap_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	assign en4 = !v_s4 || params_out.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign line_in.ready = en1;

	assign keep = (line_in.line_number > cfg.horizon_line) &&
		({24'b0, line_in.line_number} <= 32'(LINE_COUNT));

	assign ch_ext  = {{4{cfg.cam_height[27]}}, cfg.cam_height};
	assign cos_ext = {{22{cfg.yaw_cosine[9]}}, cfg.yaw_cosine};
	assign sin_ext = {{22{cfg.yaw_sine[9]}}, cfg.yaw_sine};
	assign d_ext   = {12'b0, cfg.focal_distance};

	assign lam  = asr32(prod_s1, 12);
	assign lam6 = (lam << 2) + (lam << 1);
	assign w32  = asr32(lam6, 12);
	assign w_c  = (w32 > 32'd16) ? 5'd16 : w32[4:0];

	assign lcf  = asr32(cprod_s2, 8);
	assign lsf  = asr32(sprod_s2, 8);
	assign pa_c = asr32(lcf, 4);
	assign pc_c = asr32(lsf, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= line_in.valid && keep;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			line_s1 <= line_in.line_number;
			prod_s1 <= ch_ext * {16'b0, line_in.recip_depth};
		end
		if (en2) begin
			line_s2  <= line_s1;
			cprod_s2 <= lam * cos_ext;
			sprod_s2 <= lam * sin_ext;
			w_s2     <= w_c;
		end
		if (en3) begin
			line_s3 <= line_s2;
			pa_s3   <= pa_c;
			pc_s3   <= pc_c;
			offx_s3 <= (32'(HALF_WIDTH) * pa_c) << 4;
			offy_s3 <= (32'(HALF_WIDTH) * pc_c) << 4;
			rotx_s3 <= d_ext * lsf;
			roty_s3 <= d_ext * lcf;
			w_s3    <= w_s2;
		end
		if (en4) begin
			line_s4 <= line_s3;
			pa_s4   <= pa_s3[15:0];
			pc_s4   <= pc_s3[15:0];
			sx_s4   <= asr32(32'(cfg.cam_x) - offx_s3 + rotx_s3, 4);
			sy_s4   <= asr32(32'(cfg.cam_z) - offy_s3 - roty_s3, 4);
			fog_s4  <= {w_s3, 3'b000, 5'(5'd16 - w_s3)};
		end
	end

	assign params_out.valid     = v_s4;
	assign params_out.out_line  = line_s4;
	assign params_out.step_a    = pa_s4;
	assign params_out.step_c    = pc_s4;
	assign params_out.start_x   = sx_s4;
	assign params_out.start_y   = sy_s4;
	assign params_out.fog_blend = fog_s4;

endmodule

@@ sv/m7sap_cfg_regs.sv @@
// Configuration register file of the mode 7 scanline parameter unit.
module m7sap_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [m7sap_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [m7sap_pkg::CFG_DATA_W-1:0]  wr_data,
	output m7sap_pkg::cfg_t                  cfg
);
	import m7sap_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_height     <= '0;
			cfg_q.yaw_sine       <= '0;
			cfg_q.yaw_cosine     <= 10'sd256;
			cfg_q.focal_distance <= '0;
			cfg_q.cam_x          <= '0;
			cfg_q.cam_z          <= '0;
			cfg_q.horizon_line   <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_CAM_HEIGHT:     cfg_q.cam_height     <= wr_data[27:0];
				REG_YAW_SINE:       cfg_q.yaw_sine       <= wr_data[9:0];
				REG_YAW_COSINE:     cfg_q.yaw_cosine     <= wr_data[9:0];
				REG_FOCAL_DISTANCE: cfg_q.focal_distance <= wr_data[19:0];
				REG_CAM_X:          cfg_q.cam_x          <= wr_data;
				REG_CAM_Z:          cfg_q.cam_z          <= wr_data;
				REG_HORIZON_LINE:   cfg_q.horizon_line   <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
